>>> rtl/core/hmis_pkg.sv
package hmis_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    // Sequencer phases; the unused code behaves as the toggle phase
    localparam logic [1:0] PH_TOGGLE = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    // Run outcomes
    localparam logic [1:0] OUT_NONE     = 2'd0;
    localparam logic [1:0] OUT_READY    = 2'd1;
    localparam logic [1:0] OUT_UNSTABLE = 2'd2;
    localparam logic [1:0] OUT_ABORTED  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_TOGGLES  = 3'd0;
    localparam logic [2:0] CFG_INTERVAL = 3'd1;
    localparam logic [2:0] CFG_SETTLE1  = 3'd2;
    localparam logic [2:0] CFG_SETTLE2  = 3'd3;
    localparam logic [2:0] CFG_DUTY     = 3'd4;

    // Configuration reset values
    localparam logic [7:0] RST_TOGGLES  = 8'd50;
    localparam logic [7:0] RST_INTERVAL = 8'd5;
    localparam logic [7:0] RST_SETTLE1  = 8'd12;
    localparam logic [7:0] RST_SETTLE2  = 8'd6;
    localparam logic [6:0] RST_DUTY     = 7'd10;

    localparam logic [2:0]  NUM_STEPS    = 3'd6;
    localparam logic [2:0]  LAST_SECTOR  = 3'd5;
    localparam logic [7:0]  COUNT_MAX    = 8'd255;
    localparam logic [2:0]  HALL_INVALID_LO = 3'd0;
    localparam logic [2:0]  HALL_INVALID_HI = 3'd7;
    localparam logic [31:0] MAP_CLEAR    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] toggles_per_step;
        logic [7:0] toggle_interval;
        logic [7:0] settle_first;
        logic [7:0] settle_second;
        logic [6:0] drive_duty;
    } cfg_t;

    typedef struct packed {
        logic        drive_on;
        logic [2:0]  drive_sector;
        logic [6:0]  duty_out;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  outcome;
        logic [31:0] map_out;
        logic [2:0]  unstable_steps;
    } result_t;

    // Next sector around the six-sector ring, for sectors 0..5
    function automatic logic [2:0] next_sector(input logic [2:0] s);
        return (s >= LAST_SECTOR) ? 3'd0 : s + 3'd1;
    endfunction

    // Wait count for an interval register: a zero interval acts on the next tick
    function automatic logic [7:0] delay_of(input logic [7:0] ticks);
        return (ticks != 8'd0) ? ticks - 8'd1 : 8'd0;
    endfunction

endpackage

>>> rtl/core/hmis_cfg.sv
module hmis_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [7:0]        wr_data,
    output hmis_pkg::cfg_t    cfg
);

    hmis_pkg::cfg_t cfg_reg;
    hmis_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                hmis_pkg::CFG_TOGGLES:  cfg_next.toggles_per_step = wr_data;
                hmis_pkg::CFG_INTERVAL: cfg_next.toggle_interval  = wr_data;
                hmis_pkg::CFG_SETTLE1:  cfg_next.settle_first     = wr_data;
                hmis_pkg::CFG_SETTLE2:  cfg_next.settle_second    = wr_data;
                hmis_pkg::CFG_DUTY:     cfg_next.drive_duty       = wr_data[6:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.toggles_per_step <= hmis_pkg::RST_TOGGLES;
            cfg_reg.toggle_interval  <= hmis_pkg::RST_INTERVAL;
            cfg_reg.settle_first     <= hmis_pkg::RST_SETTLE1;
            cfg_reg.settle_second    <= hmis_pkg::RST_SETTLE2;
            cfg_reg.drive_duty       <= hmis_pkg::RST_DUTY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/hmis_step.sv
module hmis_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [1:0]           kind,
    input  logic [2:0]           hall_code,
    input  logic                 fault,
    input  hmis_pkg::cfg_t       cfg,
    output hmis_pkg::result_t    result
);

    logic        active_reg,      active_next;
    logic [1:0]  phase_reg,       phase_next;
    logic [2:0]  step_index_reg,  step_index_next;
    logic [7:0]  toggle_count_reg, toggle_count_next;
    logic        toggle_second_reg, toggle_second_next;
    logic [7:0]  wait_ticks_reg,  wait_ticks_next;
    logic [2:0]  first_sample_reg, first_sample_next;
    logic [31:0] map_reg,         map_next;
    logic [2:0]  unstable_reg,    unstable_next;
    logic        drive_active_reg, drive_active_next;
    logic [2:0]  driven_sector_reg, driven_sector_next;

    logic        done;
    logic        clear;
    logic [1:0]  outcome;
    logic [2:0]  target;
    logic [7:0]  count_inc;

    always_comb
    begin
        active_next        = active_reg;
        phase_next         = phase_reg;
        step_index_next    = step_index_reg;
        toggle_count_next  = toggle_count_reg;
        toggle_second_next = toggle_second_reg;
        wait_ticks_next    = wait_ticks_reg;
        first_sample_next  = first_sample_reg;
        map_next           = map_reg;
        unstable_next      = unstable_reg;
        drive_active_next  = drive_active_reg;
        driven_sector_next = driven_sector_reg;
        done               = 1'b0;
        clear              = 1'b0;
        outcome            = hmis_pkg::OUT_NONE;
        // step_index stays below six whenever a tick is worked
        target    = hmis_pkg::next_sector(hmis_pkg::next_sector(step_index_reg));
        count_inc = (toggle_count_reg < hmis_pkg::COUNT_MAX) ?
                    toggle_count_reg + 8'd1 : toggle_count_reg;

        if (kind == hmis_pkg::KIND_START)
        begin
            clear       = 1'b1;
            active_next = 1'b1;
        end
        else if (kind == hmis_pkg::KIND_CANCEL)
        begin
            drive_active_next = 1'b0;
            if (active_reg)
            begin
                done    = 1'b1;
                outcome = hmis_pkg::OUT_ABORTED;
                clear   = 1'b1;
            end
        end
        else if (kind == hmis_pkg::KIND_TICK && active_reg)
        begin
            if (fault)
            begin
                drive_active_next = 1'b0;
                done    = 1'b1;
                outcome = hmis_pkg::OUT_ABORTED;
                clear   = 1'b1;
            end
            else if (step_index_reg >= hmis_pkg::NUM_STEPS)
            begin
                drive_active_next = 1'b0;
                done    = 1'b1;
                outcome = (unstable_reg != 3'd0) ? hmis_pkg::OUT_UNSTABLE :
                                                   hmis_pkg::OUT_READY;
                clear   = 1'b1;
            end
            else if (wait_ticks_reg != 8'd0)
            begin
                wait_ticks_next = wait_ticks_reg - 8'd1;
            end
            else
            begin
                case (phase_reg)
                    hmis_pkg::PH_FIRST:
                    begin
                        first_sample_next = hall_code;
                        phase_next        = hmis_pkg::PH_SECOND;
                        wait_ticks_next   = hmis_pkg::delay_of(cfg.settle_second);
                    end
                    hmis_pkg::PH_SECOND:
                    begin
                        if (hall_code != first_sample_reg)
                        begin
                            unstable_next = unstable_reg + 3'd1;
                        end
                        else if (hall_code != hmis_pkg::HALL_INVALID_LO &&
                                 hall_code != hmis_pkg::HALL_INVALID_HI)
                        begin
                            map_next[hall_code*4 +: 4] = {1'b0, target};
                        end
                        step_index_next    = step_index_reg + 3'd1;
                        phase_next         = hmis_pkg::PH_TOGGLE;
                        toggle_count_next  = 8'd0;
                        toggle_second_next = 1'b0;
                        wait_ticks_next    = 8'd0;
                    end
                    default:
                    begin
                        // Toggle between sector s and the one after it
                        driven_sector_next = toggle_second_reg ?
                            hmis_pkg::next_sector(step_index_reg) : step_index_reg;
                        drive_active_next  = 1'b1;
                        toggle_second_next = ~toggle_second_reg;
                        toggle_count_next  = count_inc;
                        wait_ticks_next    = hmis_pkg::delay_of(cfg.toggle_interval);
                        if (count_inc >= cfg.toggles_per_step)
                        begin
                            drive_active_next = 1'b0;
                            phase_next        = hmis_pkg::PH_FIRST;
                            wait_ticks_next   = hmis_pkg::delay_of(cfg.settle_first);
                        end
                    end
                endcase
            end
        end

        if (clear)
        begin
            active_next        = (kind == hmis_pkg::KIND_START);
            phase_next         = hmis_pkg::PH_TOGGLE;
            step_index_next    = 3'd0;
            toggle_count_next  = 8'd0;
            toggle_second_next = 1'b0;
            wait_ticks_next    = 8'd0;
            first_sample_next  = 3'd0;
            unstable_next      = 3'd0;
            map_next           = hmis_pkg::MAP_CLEAR;
        end

        result.drive_on       = drive_active_next;
        result.drive_sector   = drive_active_next ? driven_sector_next : 3'd0;
        result.duty_out       = drive_active_next ? cfg.drive_duty : 7'd0;
        result.busy_res       = active_next;
        result.done_res       = done;
        result.outcome        = outcome;
        // An ending item reports the map and count from before the clear
        result.map_out        = done ? map_reg : map_next;
        result.unstable_steps = done ? unstable_reg : unstable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            phase_reg         <= hmis_pkg::PH_TOGGLE;
            step_index_reg    <= 3'd0;
            toggle_count_reg  <= 8'd0;
            toggle_second_reg <= 1'b0;
            wait_ticks_reg    <= 8'd0;
            first_sample_reg  <= 3'd0;
            map_reg           <= hmis_pkg::MAP_CLEAR;
            unstable_reg      <= 3'd0;
            drive_active_reg  <= 1'b0;
            driven_sector_reg <= 3'd0;
        end
        else if (step_en)
        begin
            active_reg        <= active_next;
            phase_reg         <= phase_next;
            step_index_reg    <= step_index_next;
            toggle_count_reg  <= toggle_count_next;
            toggle_second_reg <= toggle_second_next;
            wait_ticks_reg    <= wait_ticks_next;
            first_sample_reg  <= first_sample_next;
            map_reg           <= map_next;
            unstable_reg      <= unstable_next;
            drive_active_reg  <= drive_active_next;
            driven_sector_reg <= driven_sector_next;
        end
    end

endmodule

>>> rtl/core/hall_map_identify_sequencer.sv
// Latency: a result item is valid on the cycle after its input item is accepted.
// Throughput: one item per cycle while results are taken; the output register lets a new item
// enter in the same cycle that the held result is taken.
// Reset (rst_n low, asynchronous): sequencer idle with its drive state off, map all unassigned,
// configuration back to its defaults, no result pending.
module hall_map_identify_sequencer (
    input  logic        clk,
    input  logic        rst_n,

    // Input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [2:0]  hall_code,
    input  logic        fault,

    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    // Result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic        drive_on,
    output logic [2:0]  drive_sector,
    output logic [6:0]  duty_out,
    output logic        busy_res,
    output logic        done_res,
    output logic [1:0]  outcome,
    output logic [31:0] map_out,
    output logic [2:0]  unstable_steps
);

    hmis_pkg::cfg_t    cfg;
    hmis_pkg::result_t step_result;
    hmis_pkg::result_t result_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              in_accept;

    // Configuration writes are always accepted
    assign cfg_ready = 1'b1;

    hmis_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Accept a new item whenever the result slot is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Advance the sequencer state only on an accepted item
    hmis_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (in_accept),
        .kind      (kind),
        .hall_code (hall_code),
        .fault     (fault),
        .cfg       (cfg),
        .result    (step_result)
    );

    // Hold the result until it is taken; drop valid once drained with nothing new
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register, loaded with each accepted item's result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_on       = result_reg.drive_on;
    assign drive_sector   = result_reg.drive_sector;
    assign duty_out       = result_reg.duty_out;
    assign busy_res       = result_reg.busy_res;
    assign done_res       = result_reg.done_res;
    assign outcome        = result_reg.outcome;
    assign map_out        = result_reg.map_out;
    assign unstable_steps = result_reg.unstable_steps;

endmodule
